// ===== src/ptns_pkg.sv =====
// ----------------------------------------------------------------------------
// ptns_pkg - shared definitions for the pixel temporal noise statistics block
// Array geometry, field widths, codes, state and control types.
// ----------------------------------------------------------------------------
package ptns_pkg;

    localparam int ROWS        = 24;
    localparam int COLS        = 32;
    localparam int CELLS       = ROWS * COLS;
    localparam int MAX_SAMPLES = 50;

    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int ACTION_W = 2;
    localparam int CNT_W    = 6;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 22;
    localparam int SQ_W     = 37;
    localparam int FIG_W    = 30;
    localparam int DONE_W   = 10;

    localparam int MUL_W    = 22;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W;
    localparam int NN_W     = 12;
    localparam int STEP_W   = $clog2(FIG_W + 1);
    localparam int HEAD_W   = ACC_W - FIG_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;

    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_METRIC_MODE  = 1'b1;

    localparam logic METRIC_RANGE    = 1'b0;
    localparam logic METRIC_VARIANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SQ,
        ST_SUB,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD_HI,
        MAC_SUB_CLAMP
    } mac_op_t;

    typedef struct packed {
        logic [CNT_W-1:0]    cnt;
        logic [SAMPLE_W-1:0] min_val;
        logic [SAMPLE_W-1:0] max_val;
        logic [SUM_W-1:0]    sum_val;
        logic [SQ_W-1:0]     sumsq_val;
    } cell_t;

    typedef struct packed {
        mac_op_t          op;
        logic [MUL_W-1:0] op_a;
        logic [MUL_W-1:0] op_b;
    } mac_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [FIG_W-1:0] quotient;
    } div_result_t;

endpackage

// ===== src/pixel_temporal_noise_stats.sv =====
// ----------------------------------------------------------------------------
// pixel_temporal_noise_stats - per-pixel temporal noise range / variance
// Accumulates count, min, max, sum and sum of squares per cell and emits
// the cell's noise figure when its count reaches sample_count.
// ----------------------------------------------------------------------------
// Flow: start, stop, unused codes and samples with no series active end in IDLE;
//   a sample to a cell outside the array passes READ; a sample passes READ and
//   UPDATE; a completion adds OUT (range) or the multiply, subtract and divide
//   states, then OUT (variance), plus any wait on the result. One item at a time;
//   the variance path runs through the shared multiplier and the 30-step divider.
// Reset: control cleared, config set to count 1 and range mode, then a pass over
//   all 768 cells zeroes the cell counts; items are not taken until it ends.
module pixel_temporal_noise_stats (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptns_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ptns_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ptns_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [ptns_pkg::ACTION_W-1:0]     action,
    input  logic [ptns_pkg::ROW_W-1:0]        row,
    input  logic [ptns_pkg::COL_W-1:0]        col,
    input  logic signed [ptns_pkg::SAMPLE_W-1:0] value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [ptns_pkg::ROW_W-1:0]        out_row,
    output logic [ptns_pkg::COL_W-1:0]        out_col,
    output logic [ptns_pkg::FIG_W-1:0]        noise_figure,
    output logic                              series_done
);
    import ptns_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    sample_count_reg, sample_count_next;
    logic                metric_mode_reg, metric_mode_next;
    logic                series_active_reg, series_active_next;
    logic [DONE_W-1:0]   completions_reg, completions_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                result_valid_reg, result_valid_next;

    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]     sumsq_reg, sumsq_next;
    logic [FIG_W-1:0]    fig_reg, fig_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [FIG_W-1:0]    out_fig_reg, out_fig_next;
    logic                out_done_reg, out_done_next;

    logic                apb_write;
    logic                item_fire;
    logic                row_ok;
    logic                col_ok;
    logic                out_free;
    logic [DONE_W:0]     completions_inc;
    logic                series_end;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    cell_t               mem_wdata;
    cell_t               mem_rdata;

    mac_ctrl_t           mac_ctrl;
    logic [PROD_W-1:0]   mac_prod;
    logic [ACC_W-1:0]    mac_acc;
    logic                div_start;
    div_result_t         div_res;

    logic [SAMPLE_W:0]   v_ext;
    logic [SAMPLE_W:0]   v_mag;
    logic [SUM_W-1:0]    v_sum_ext;
    logic [SUM_W-1:0]    sum_mag;
    logic                upd_taken;
    logic                upd_first;
    logic                upd_complete;
    cell_t               upd_cell;
    logic [SAMPLE_W:0]   upd_range;

    // configuration port
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        metric_mode_next  = metric_mode_reg;
        if (apb_write)
        begin
            case (paddr[2])
                REG_SAMPLE_COUNT: sample_count_next = pwdata[CNT_W-1:0];
                REG_METRIC_MODE:  metric_mode_next  = pwdata[0];
                default:          sample_count_next = sample_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SAMPLE_COUNT: prdata = APB_DATA_W'(sample_count_reg);
            REG_METRIC_MODE:  prdata = APB_DATA_W'(metric_mode_reg);
            default:          prdata = '0;
        endcase
    end

    // item decode
    assign item_fire = item_valid && item_ready;
    assign row_ok    = {1'b0, row_reg} < (ROW_W + 1)'(ROWS);
    assign col_ok    = {1'b0, col_reg} < (COL_W + 1)'(COLS);
    assign out_free  = !result_valid_reg || result_ready;

    assign completions_inc = {1'b0, completions_reg} + (DONE_W + 1)'(1);
    assign series_end      = completions_inc >= (DONE_W + 1)'(CELLS);

    // cell update
    assign v_ext     = {value_reg[SAMPLE_W-1], value_reg};
    assign v_mag     = v_ext[SAMPLE_W] ? (~v_ext + (SAMPLE_W + 1)'(1)) : v_ext;
    assign v_sum_ext = {{(SUM_W - SAMPLE_W){value_reg[SAMPLE_W-1]}}, value_reg};
    assign sum_mag   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;

    always_comb
    begin
        upd_taken = (mem_rdata.cnt < sample_count_reg)
                    && (sample_count_reg <= CNT_W'(MAX_SAMPLES));
        upd_first = (mem_rdata.cnt == '0);
        upd_cell  = mem_rdata;
        if (upd_taken)
        begin
            upd_cell.cnt = mem_rdata.cnt + CNT_W'(1);
            if (upd_first)
            begin
                upd_cell.min_val   = value_reg;
                upd_cell.max_val   = value_reg;
                upd_cell.sum_val   = v_sum_ext;
                upd_cell.sumsq_val = mac_prod[SQ_W-1:0];
            end
            else
            begin
                if ($signed(value_reg) < $signed(mem_rdata.min_val))
                begin
                    upd_cell.min_val = value_reg;
                end
                if ($signed(value_reg) > $signed(mem_rdata.max_val))
                begin
                    upd_cell.max_val = value_reg;
                end
                upd_cell.sum_val   = mem_rdata.sum_val + v_sum_ext;
                upd_cell.sumsq_val = mem_rdata.sumsq_val + mac_prod[SQ_W-1:0];
            end
        end
        upd_complete = (upd_cell.cnt != '0) && (upd_cell.cnt == sample_count_reg);
        upd_range    = {upd_cell.max_val[SAMPLE_W-1], upd_cell.max_val}
                       - {upd_cell.min_val[SAMPLE_W-1], upd_cell.min_val};
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire && action == ACT_SAMPLE && series_active_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = (row_ok && col_ok) ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                if (!upd_complete)
                begin
                    state_next = ST_IDLE;
                end
                else if (metric_mode_reg == METRIC_VARIANCE)
                begin
                    state_next = ST_MUL_LO;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_MUL_SQ;
            ST_MUL_SQ:    state_next = ST_SUB;
            ST_SUB:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (div_res.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer: control outputs
    always_comb
    begin
        item_ready    = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = upd_cell;
        mac_ctrl.op   = MAC_HOLD;
        mac_ctrl.op_a = '0;
        mac_ctrl.op_b = '0;
        div_start     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_READ:
            begin
                mac_ctrl.op_a = MUL_W'(v_mag);
                mac_ctrl.op_b = MUL_W'(v_mag);
            end
            ST_UPDATE:
            begin
                mem_we = upd_taken || upd_complete;
                if (upd_complete)
                begin
                    mem_wdata.cnt = '0;
                end
            end
            ST_MUL_LO:
            begin
                mac_ctrl.op_a = MUL_W'(n_reg);
                mac_ctrl.op_b = sumsq_reg[MUL_W-1:0];
            end
            ST_MUL_HI:
            begin
                mac_ctrl.op   = MAC_LOAD;
                mac_ctrl.op_a = MUL_W'(n_reg);
                mac_ctrl.op_b = MUL_W'(sumsq_reg[SQ_W-1:MUL_W]);
            end
            ST_MUL_SQ:
            begin
                mac_ctrl.op   = MAC_ADD_HI;
                mac_ctrl.op_a = sum_mag;
                mac_ctrl.op_b = sum_mag;
            end
            ST_SUB:
            begin
                mac_ctrl.op   = MAC_SUB_CLAMP;
                mac_ctrl.op_a = MUL_W'(n_reg);
                mac_ctrl.op_b = MUL_W'(n_reg);
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // datapath and bookkeeping registers
    always_comb
    begin
        series_active_next = series_active_reg;
        completions_next   = completions_reg;
        clr_addr_next      = clr_addr_reg;
        result_valid_next  = result_valid_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        value_next         = value_reg;
        addr_next          = addr_reg;
        n_next             = n_reg;
        sum_next           = sum_reg;
        sumsq_next         = sumsq_reg;
        fig_next           = fig_reg;
        out_row_next       = out_row_reg;
        out_col_next       = out_col_reg;
        out_fig_next       = out_fig_reg;
        out_done_next      = out_done_reg;

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    row_next   = row;
                    col_next   = col;
                    value_next = value;
                    addr_next  = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
                    if (action == ACT_START && !series_active_reg)
                    begin
                        series_active_next = 1'b1;
                        completions_next   = '0;
                    end
                    else if (action == ACT_STOP)
                    begin
                        series_active_next = 1'b0;
                    end
                end
            end
            ST_UPDATE:
            begin
                n_next     = upd_cell.cnt;
                sum_next   = upd_cell.sum_val;
                sumsq_next = upd_cell.sumsq_val;
                fig_next   = FIG_W'(upd_range);
            end
            ST_DIV_RUN:
            begin
                if (div_res.done)
                begin
                    fig_next = div_res.quotient;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    out_row_next      = row_reg;
                    out_col_next      = col_reg;
                    out_fig_next      = fig_reg;
                    out_done_next     = series_end;
                    completions_next  = completions_inc[DONE_W-1:0];
                    if (series_end)
                    begin
                        series_active_next = 1'b0;
                    end
                end
            end
            default:
            begin
                clr_addr_next = clr_addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            sample_count_reg  <= CNT_W'(1);
            metric_mode_reg   <= METRIC_RANGE;
            series_active_reg <= 1'b0;
            completions_reg   <= '0;
            clr_addr_reg      <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sample_count_reg  <= sample_count_next;
            metric_mode_reg   <= metric_mode_next;
            series_active_reg <= series_active_next;
            completions_reg   <= completions_next;
            clr_addr_reg      <= clr_addr_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        value_reg    <= value_next;
        addr_reg     <= addr_next;
        n_reg        <= n_next;
        sum_reg      <= sum_next;
        sumsq_reg    <= sumsq_next;
        fig_reg      <= fig_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_fig_reg  <= out_fig_next;
        out_done_reg <= out_done_next;
    end

    ptns_cell_mem u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    ptns_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    ptns_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (mac_acc),
        .den    (mac_prod[NN_W-1:0]),
        .result (div_res)
    );

    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign noise_figure = out_fig_reg;
    assign series_done  = out_done_reg;

endmodule

// ===== src/ptns_cell_mem.sv =====
// ----------------------------------------------------------------------------
// ptns_cell_mem - per-cell statistics memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptns_cell_mem (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ptns_pkg::ADDR_W-1:0] waddr,
    input  ptns_pkg::cell_t           wdata,
    input  logic [ptns_pkg::ADDR_W-1:0] raddr,
    output ptns_pkg::cell_t           rdata
);
    import ptns_pkg::*;

    cell_t cell_ram [CELLS];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= cell_ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptns_mac.sv =====
// ----------------------------------------------------------------------------
// ptns_mac - shared multiplier with accumulator
// Registered 22x22 product; accumulator holds, loads, adds the product shifted up
// by one operand width, or subtracts it with a floor at zero.
// ----------------------------------------------------------------------------
module ptns_mac (
    input  logic                      clk,
    input  ptns_pkg::mac_ctrl_t       ctrl,
    output logic [ptns_pkg::PROD_W-1:0] prod,
    output logic [ptns_pkg::ACC_W-1:0]  acc
);
    import ptns_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;

    assign prod_next = PROD_W'(ctrl.op_a) * PROD_W'(ctrl.op_b);

    always_comb
    begin
        case (ctrl.op)
            MAC_HOLD:      acc_next = acc_reg;
            MAC_LOAD:      acc_next = prod_reg;
            MAC_ADD_HI:    acc_next = acc_reg + (prod_reg << MUL_W);
            MAC_SUB_CLAMP: acc_next = (acc_reg > prod_reg) ? acc_reg - prod_reg : '0;
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== src/ptns_div.sv =====
// ----------------------------------------------------------------------------
// ptns_div - iterative restoring divider
// One quotient bit per cycle; quotient saturates when it would not fit
// in the figure width.
// ----------------------------------------------------------------------------
module ptns_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ptns_pkg::ACC_W-1:0] num,
    input  logic [ptns_pkg::NN_W-1:0]  den,
    output ptns_pkg::div_result_t      result
);
    import ptns_pkg::*;

    logic [NN_W-1:0]   rem_reg;
    logic [NN_W-1:0]   rem_next;
    logic [FIG_W-1:0]  quo_reg;
    logic [FIG_W-1:0]  quo_next;
    logic [NN_W-1:0]   den_reg;
    logic [NN_W-1:0]   den_next;
    logic [STEP_W-1:0] left_reg;
    logic [STEP_W-1:0] left_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [NN_W:0]     trial;
    logic [NN_W:0]     trial_diff;
    logic              trial_ge;
    logic              overflow;

    assign trial      = {rem_reg, quo_reg[FIG_W-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};
    assign overflow   = num[ACC_W-1:FIG_W] >= HEAD_W'(den);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next = den;
            if (overflow)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = num[FIG_W+NN_W-1:FIG_W];
                quo_next  = num[FIG_W-1:0];
                left_next = STEP_W'(FIG_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = trial_ge ? trial_diff[NN_W-1:0] : trial[NN_W-1:0];
            quo_next  = {quo_reg[FIG_W-2:0], trial_ge};
            left_next = left_reg - STEP_W'(1);
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for pixel_temporal_noise_stats
// Drives sample, start and stop items with random gaps and output stalls.
// A cycle-free predictor of the per-cell range and variance runs at every
// accepted item. Each result is compared in order with what it predicts.
// A directed table comes first, then random phases with new settings, and
// last one full series run to its end.
// ----------------------------------------------------------------------------
module tb_top;
    import ptns_pkg::*;

    localparam logic [ACTION_W-1:0]   ACT_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_COUNT = {REG_SAMPLE_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MODE  = {REG_METRIC_MODE, 2'b00};
    localparam longint unsigned FIG_MAX = (64'd1 << FIG_W) - 1;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_NS      = 4_000_000;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [SAMPLE_W-1:0] value;
    } pix_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [FIG_W-1:0] fig;
        logic             done;
    } noise_res_t;

    typedef enum logic [1:0] {
        K_ITEM,
        K_CHECKED,
        K_COUNT,
        K_MODE
    } step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        pix_item_t        stim;
        noise_res_t       want;
        logic [CNT_W-1:0] cfg;
    } step_t;

    localparam step_t DIRECTED [29] = '{
        '{K_ITEM,    '{ACT_SAMPLE, 5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_START,  5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_CHECKED, '{ACT_SAMPLE, 5'd0,  5'd0,  16'h8000}, '{5'd0, 5'd0, 30'd0, 1'b0}, 6'd0},
        '{K_CHECKED, '{ACT_SAMPLE, 5'd23, 5'd31, 16'h7FFF}, '{5'd23, 5'd31, 30'd0, 1'b0}, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd24, 5'd5,  16'h1234}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd31, 5'd31, 16'hFFFF}, '0, 6'd0},
        '{K_ITEM,    '{ACT_UNUSED, 5'd1,  5'd1,  16'h0001}, '0, 6'd0},
        '{K_ITEM,    '{ACT_START,  5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_STOP,   5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_STOP,   5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_COUNT,   '0, '0, 6'd3},
        '{K_ITEM,    '{ACT_START,  5'd0,  5'd0,  16'h0000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd5,  5'd7,  16'h8000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd5,  5'd7,  16'h7FFF}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd6,  5'd8,  16'hFC18}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd6,  5'd8,  16'h07D0}, '0, 6'd0},
        '{K_COUNT,   '0, '0, 6'd2},
        '{K_CHECKED, '{ACT_SAMPLE, 5'd5,  5'd7,  16'd100},
                     '{5'd5, 5'd7, 30'd65535, 1'b0}, 6'd0},
        '{K_COUNT,   '0, '0, 6'd1},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd6,  5'd8,  16'd5},    '0, 6'd0},
        '{K_COUNT,   '0, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd1,  5'd1,  16'd7},    '0, 6'd0},
        '{K_COUNT,   '0, '0, 6'd63},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd1,  5'd1,  16'd7},    '0, 6'd0},
        '{K_COUNT,   '0, '0, 6'd3},
        '{K_MODE,    '0, '0, 6'd1},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd6,  5'd8,  16'h8000}, '0, 6'd0},
        '{K_ITEM,    '{ACT_SAMPLE, 5'd2,  5'd3,  16'h7FFF}, '0, 6'd0},
        '{K_ITEM,    '{ACT_STOP,   5'd0,  5'd0,  16'h0000}, '0, 6'd0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    item_valid;
    logic                    item_ready;
    logic [ACTION_W-1:0]     action;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [SAMPLE_W-1:0] value;
    logic                    result_valid;
    logic                    result_ready;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic [FIG_W-1:0]        noise_figure;
    logic                    series_done;

    // predictor state
    logic [CNT_W-1:0]  cfg_count;
    logic              cfg_mode;
    bit [CNT_W-1:0]    fill [CELLS];
    int                lo [CELLS];
    int                hi [CELLS];
    longint            acc [CELLS];
    longint unsigned   acc_sq [CELLS];
    int unsigned       done_cells;
    bit                series_on;

    noise_res_t expected_figures [$];
    int  fail_count;
    int  taken_items;
    int  gap_pct;
    int  stall_pct;
    bit  hold_req;
    int  win_row;
    int  win_rows;
    int  win_col;
    int  win_cols;

    pixel_temporal_noise_stats dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .row          (row),
        .col          (col),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_row      (out_row),
        .out_col      (out_col),
        .noise_figure (noise_figure),
        .series_done  (series_done)
    );

    always #1 clk = ~clk;

    function automatic bit predict_cell_update(input pix_item_t it, output noise_res_t res,
                                               output bit took);
        int unsigned     idx;
        int unsigned     n;
        int              v;
        longint unsigned mag;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned num;
        longint unsigned fig;
        res = '0;
        took = 1'b0;
        if (it.action == ACT_START)
        begin
            took = !series_on;
            if (!series_on)
            begin
                series_on = 1'b1;
                done_cells = 0;
            end
            return 1'b0;
        end
        if (it.action == ACT_STOP)
        begin
            took = series_on;
            series_on = 1'b0;
            return 1'b0;
        end
        if (it.action != ACT_SAMPLE || !series_on || it.row >= ROWS || it.col >= COLS)
            return 1'b0;
        idx = it.row * COLS + it.col;
        n = fill[idx];
        v = $signed(it.value);
        if (n < cfg_count && cfg_count <= MAX_SAMPLES)
        begin
            if (n == 0)
            begin
                lo[idx] = v;
                hi[idx] = v;
                acc[idx] = v;
                acc_sq[idx] = longint'(v) * longint'(v);
            end
            else
            begin
                if (v < lo[idx])
                    lo[idx] = v;
                if (v > hi[idx])
                    hi[idx] = v;
                acc[idx] += v;
                acc_sq[idx] += longint'(v) * longint'(v);
            end
            n++;
            fill[idx] = CNT_W'(n);
            took = 1'b1;
        end
        if (n == 0 || n != cfg_count)
            return 1'b0;
        took = 1'b1;
        if (cfg_mode == METRIC_RANGE)
            fig = longint'(hi[idx]) - longint'(lo[idx]);
        else
        begin
            mag = (acc[idx] < 0) ? -acc[idx] : acc[idx];
            lhs = n * acc_sq[idx];
            rhs = mag * mag;
            num = (lhs > rhs) ? lhs - rhs : 64'd0;
            fig = num / (n * n);
        end
        if (fig > FIG_MAX)
            fig = FIG_MAX;
        fill[idx] = '0;
        done_cells++;
        res.row = it.row;
        res.col = it.col;
        res.fig = fig[FIG_W-1:0];
        res.done = 1'b0;
        if (done_cells >= CELLS)
        begin
            res.done = 1'b1;
            series_on = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return SAMPLE_W'($urandom_range(0, 16)) - 16'd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly samples into the current window of cells, some noise
    function automatic pix_item_t pick_item(input bit allow_stop);
        pix_item_t it;
        it.action = ACT_SAMPLE;
        it.row = ROW_W'(win_row + $urandom_range(0, win_rows - 1));
        it.col = COL_W'(win_col + $urandom_range(0, win_cols - 1));
        it.value = pick_value();
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 4))
                0: it.action = ACT_UNUSED;
                1: it.row = ROW_W'($urandom_range(ROWS, (1 << ROW_W) - 1));
                2:
                begin
                    it.row = ROW_W'($urandom_range(0, ROWS - 1));
                    it.col = COL_W'($urandom_range(0, COLS - 1));
                end
                3: it.action = ACT_START;
                default: it.action = allow_stop ? ACT_STOP : ACT_START;
            endcase
        end
        return it;
    endfunction

    function automatic pix_item_t ctrl_item(input logic [ACTION_W-1:0] act);
        pix_item_t it;
        it.action = act;
        it.row = ROW_W'($urandom);
        it.col = COL_W'($urandom);
        it.value = SAMPLE_W'($urandom);
        return it;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic send_item(input pix_item_t it, input bit typed, input noise_res_t typed_res);
        noise_res_t res;
        bit         took;
        bit         got;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= it.action;
        row <= it.row;
        col <= it.col;
        value <= it.value;
        do @(posedge clk); while (!item_ready);
        got = predict_cell_update(it, res, took);
        if (took)
            taken_items++;
        if (typed)
            expected_figures.push_back(typed_res);
        else if (got)
            expected_figures.push_back(res);
    endtask

    // wait for every expected figure, then let the block go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_figures.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_COUNT)
            cfg_count = data[CNT_W-1:0];
        else if (addr == ADDR_MODE)
            cfg_mode = data[0];
        @(posedge clk);
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int hold_cnt;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                hold_req = 1'b0;
                result_ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        noise_res_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_figures.size() == 0)
                note_mismatch($sformatf("unexpected result row %0d col %0d figure %0d done %0d",
                                        out_row, out_col, noise_figure, series_done));
            else
            begin
                want = expected_figures.pop_front();
                if (out_row !== want.row || out_col !== want.col ||
                    noise_figure !== want.fig || series_done !== want.done)
                    note_mismatch($sformatf(
                        "exp row %0d col %0d figure %0d done %0d, got %0d %0d %0d %0d",
                        want.row, want.col, want.fig, want.done,
                        out_row, out_col, noise_figure, series_done));
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("pixel_temporal_noise_stats test failed");
        $finish;
    end

    initial
    begin
        int               phase_no;
        int               n_items;
        int               guard;
        logic [CNT_W-1:0] pick_count;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_valid <= 1'b0;
        action <= ACT_SAMPLE;
        row <= '0;
        col <= '0;
        value <= '0;
        cfg_count = 6'd1;
        cfg_mode = METRIC_RANGE;
        foreach (fill[i])
            fill[i] = '0;
        done_cells = 0;
        series_on = 1'b0;
        fail_count = 0;
        taken_items = 0;
        hold_req = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 20;
        stall_pct = 20;
        foreach (DIRECTED[i])
        begin
            case (DIRECTED[i].kind)
                K_ITEM:    send_item(DIRECTED[i].stim, 1'b0, '0);
                K_CHECKED: send_item(DIRECTED[i].stim, 1'b1, DIRECTED[i].want);
                K_COUNT:
                begin
                    settle();
                    write_reg(ADDR_COUNT, APB_DATA_W'(DIRECTED[i].cfg));
                end
                default:
                begin
                    settle();
                    write_reg(ADDR_MODE, APB_DATA_W'(DIRECTED[i].cfg));
                end
            endcase
        end

        // random phases, each with its own settings and a small window of cells
        phase_no = 0;
        while (taken_items < 600 && phase_no < 40)
        begin
            settle();
            if (phase_no == 1)
                pick_count = 6'd1;
            else
            begin
                case ($urandom_range(0, 19))
                    0:       pick_count = 6'd0;
                    1:       pick_count = CNT_W'($urandom_range(MAX_SAMPLES + 1, 63));
                    2, 3:    pick_count = CNT_W'(MAX_SAMPLES);
                    4, 5:    pick_count = 6'd1;
                    default: pick_count = CNT_W'($urandom_range(2, 8));
                endcase
            end
            write_reg(ADDR_COUNT, APB_DATA_W'(pick_count));
            write_reg(ADDR_MODE, APB_DATA_W'($urandom_range(0, 1)));
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            if (pick_count >= 20)
            begin
                win_rows = 1;
                win_cols = 1;
                n_items = 2 * pick_count + 10;
            end
            else
            begin
                win_rows = $urandom_range(1, 2);
                win_cols = $urandom_range(1, 4);
                n_items = $urandom_range(30, 120);
            end
            win_row = $urandom_range(0, ROWS - win_rows);
            win_col = $urandom_range(0, COLS - win_cols);
            // output held off while samples keep coming
            if (phase_no == 1)
                hold_req = 1'b1;
            if (phase_no == 1 || $urandom_range(0, 9) != 0)
                send_item(ctrl_item(ACT_START), 1'b0, '0);
            repeat (n_items)
                send_item(pick_item(phase_no != 1), 1'b0, '0);
            if ($urandom_range(0, 1) != 0)
                send_item(ctrl_item(ACT_STOP), 1'b0, '0);
            phase_no++;
        end

        // one full series up to its last completion, no idling
        settle();
        write_reg(ADDR_COUNT, APB_DATA_W'(1));
        write_reg(ADDR_MODE, APB_DATA_W'($urandom_range(0, 1)));
        gap_pct = 0;
        stall_pct = 0;
        win_row = 0;
        win_rows = ROWS;
        win_col = 0;
        win_cols = COLS;
        send_item(ctrl_item(ACT_STOP), 1'b0, '0);
        send_item(ctrl_item(ACT_START), 1'b0, '0);
        guard = 0;
        while (series_on && guard < 4000)
        begin
            send_item(pick_item(1'b0), 1'b0, '0);
            guard++;
        end
        repeat (3)
            send_item(pick_item(1'b0), 1'b0, '0);

        settle();
        if (fail_count == 0)
            $display("pixel_temporal_noise_stats test passed");
        else
            $display("pixel_temporal_noise_stats test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ptns_pkg.sv
src/ptns_cell_mem.sv
src/ptns_mac.sv
src/ptns_div.sv
src/pixel_temporal_noise_stats.sv
bench/tb_top.sv
